FILE: rtl/oriented_box_ground_query_top_assert.svh
// Assertion macros for the oriented box ground query block.
// Used by oriented_box_ground_query_top; no other dependencies.
`ifndef ORIENTED_BOX_GROUND_QUERY_TOP_ASSERT_SVH
`define ORIENTED_BOX_GROUND_QUERY_TOP_ASSERT_SVH

// same-cycle implication
`define OBGQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obgq same-cycle check failed");

// next-cycle implication
`define OBGQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obgq next-cycle check failed");

`endif

FILE: rtl/obgq_pkg.sv
// Shared constants for the oriented box ground query block.
// No dependencies.
package obgq_pkg;
    localparam int MAX_BOXES = 64;
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    // packed entry: center_x, center_y, half_width, cosine, sine
    localparam int ENTRY_W = 32 + 32 + 31 + 18 + 18;
    localparam int GROUND_OFFSET = 9;
    localparam int NO_GROUND = 100 << 16;
    localparam int FEET_SLACK = 'h4000;
    localparam int DIV_STEPS = 50;
    localparam int DIV_CW = $clog2(DIV_STEPS);
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
endpackage

FILE: rtl/obgq_ram.sv
// Generic single write port, single registered read port RAM.
// No dependencies.
module obgq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/oriented_box_ground_query_top.sv
// Top level of the oriented box ground query block.
// Depends on obgq_pkg, obgq_ram and oriented_box_ground_query_top_assert.svh.
//
// channel   dir  handshake                     payload
// -------   ---  ----------------------------  ---------------------------------
// in        in   i_in_valid / o_in_ready       i_cmd .. i_feet_height
// out       out  o_out_valid / i_out_ready     o_ground_height, o_found
// cfg       in   i_cfg_valid / o_cfg_ready     i_cfg_data (box_count)
//
// A box write is one transfer. A query walks the boxes in turn: each is addressed
// (ADDR), read (LOAD) and classified (PREP); a vertical-axis box or an x-span
// miss stops there, an axis-aligned hit goes to CMP, and a rotated box runs the
// restoring divider (DIV, one quotient bit per cycle) then MUL, and on a hit SUM
// and CMP. The result is then offered on the output channel.
// Reset clears the sequencer, box_count and the output valid; the table is not
// cleared. While a query runs or a result waits, o_in_ready stays low.
`include "oriented_box_ground_query_top_assert.svh"
module oriented_box_ground_query_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [5:0]         i_box_index,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic [30:0]        i_half_width,
    input  logic signed [17:0] i_cosine,
    input  logic signed [17:0] i_sine,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_feet_height,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_ground_height,
    output logic               o_found,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [6:0]         i_cfg_data
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ADDR = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_PREP = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_CMP  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0]                   r_state;
    logic [6:0]                   r_box_count;
    logic [obgq_pkg::CW-1:0]      r_idx;
    logic [obgq_pkg::CW-1:0]      r_n;
    logic signed [31:0]           r_qx;
    logic signed [32:0]           r_limit;
    logic signed [35:0]           r_best;
    logic                         r_found;
    logic signed [31:0]           r_cy;
    logic [30:0]                  r_hw;
    logic signed [17:0]           r_c;
    logic signed [17:0]           r_s;
    logic signed [33:0]           r_dx;
    logic                         r_neg;
    logic [49:0]                  r_dvd;
    logic [16:0]                  r_dvs;
    logic [16:0]                  r_rem;
    logic [obgq_pkg::DIV_CW-1:0]  r_cnt;
    logic signed [49:0]           r_prod;
    logic signed [35:0]           r_g;
    logic signed [31:0]           r_out_ground;
    logic                         r_out_found;

    logic                         in_xfer;
    logic                         wr_en;
    logic [15:0]                  wr_idx_ext;
    logic [obgq_pkg::ENTRY_W-1:0] wr_data;
    logic [obgq_pkg::ENTRY_W-1:0] rd_data;
    logic [15:0]                  n_count;
    logic signed [33:0]           num;
    logic [33:0]                  num_mag;
    logic [33:0]                  dx_mag;
    logic [17:0]                  rem_sh;
    logic [17:0]                  rem_diff;
    logic signed [31:0]           t_val;
    logic signed [35:0]           g_rot;
    logic signed [35:0]           g_axis;
    logic signed [35:0]           c9;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign wr_idx_ext  = 16'(i_box_index);
    assign wr_en       = in_xfer && (i_cmd == obgq_pkg::CMD_WRITE)
                         && (wr_idx_ext < 16'(obgq_pkg::MAX_BOXES));
    assign wr_data     = {i_center_x, i_center_y, i_half_width, i_cosine, i_sine};

    obgq_ram #(
        .WIDTH (obgq_pkg::ENTRY_W),
        .DEPTH (obgq_pkg::MAX_BOXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_idx_ext[obgq_pkg::AW-1:0]),
        .i_wdata (wr_data),
        .i_raddr ((obgq_pkg::AW)'(r_idx)),
        .o_rdata (rd_data)
    );

    // clamp the searched count to the table depth
    assign n_count = (16'(r_box_count) > 16'(obgq_pkg::MAX_BOXES))
                     ? 16'(obgq_pkg::MAX_BOXES) : 16'(r_box_count);

    // num = dx + floor(9*sin / 65536)
    assign num     = r_dx + 34'((36'(r_s) * 36'sd9) >>> 16);
    assign num_mag = num[33] ? 34'(-num) : 34'(num);
    assign dx_mag  = r_dx[33] ? 34'(-r_dx) : 34'(r_dx);

    // one restoring divide step
    assign rem_sh   = {r_rem, r_dvd[49]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    assign t_val  = r_neg ? -$signed({1'b0, r_dvd[30:0]}) : $signed({1'b0, r_dvd[30:0]});
    assign c9     = 36'(r_c) * 36'sd9;
    assign g_rot  = -(36'(r_cy) + 36'(r_prod >>> 16) + c9);
    assign g_axis = -(36'(r_cy) + 36'(obgq_pkg::GROUND_OFFSET * 65536));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_box_count <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_box_count <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && i_cmd == obgq_pkg::CMD_QUERY) begin
                        r_qx    <= i_query_x;
                        r_limit <= 33'(i_feet_height) - 33'(obgq_pkg::FEET_SLACK);
                        r_best  <= 36'(obgq_pkg::NO_GROUND);
                        r_found <= 1'b0;
                        r_idx   <= '0;
                        r_n     <= n_count[obgq_pkg::CW-1:0];
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    if (r_idx == r_n) begin
                        // saturate below -2^31
                        if (r_best < -36'sh80000000) begin
                            r_out_ground <= 32'sh80000000;
                        end else begin
                            r_out_ground <= r_best[31:0];
                        end
                        r_out_found <= r_found;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_dx    <= 34'(r_qx) - 34'($signed(rd_data[130:99]));
                    r_cy    <= rd_data[98:67];
                    r_hw    <= rd_data[66:36];
                    r_c     <= rd_data[35:18];
                    r_s     <= rd_data[17:0];
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (r_c == '0 && r_s == '0) begin
                        if (dx_mag <= 34'(r_hw)) begin
                            r_g     <= g_axis;
                            r_state <= S_CMP;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_ADDR;
                        end
                    end else if (r_c == '0) begin
                        // vertical axis: skipped, no divide
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ADDR;
                    end else begin
                        r_neg   <= num[33] ^ r_c[17];
                        r_dvd   <= {num_mag, 16'b0};
                        r_dvs   <= r_c[17] ? 17'(-r_c) : 17'(r_c);
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_sh >= {1'b0, r_dvs}) begin
                        r_rem <= rem_diff[16:0];
                        r_dvd <= {r_dvd[48:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh[16:0];
                        r_dvd <= {r_dvd[48:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == (obgq_pkg::DIV_CW)'(obgq_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // |t| against half width; t then fits 32 bits
                    if (r_dvd > 50'(r_hw)) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_ADDR;
                    end else begin
                        r_prod  <= 50'(t_val) * 50'(r_s);
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_g     <= g_rot;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_g >= 36'(r_limit) && r_g < r_best) begin
                        r_best  <= r_g;
                        r_found <= 1'b1;
                    end
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_ADDR;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = (r_state == S_OUT);
    assign o_ground_height = r_out_ground;
    assign o_found         = r_out_found;

    `OBGQ_ASSERT_NOW(a_no_accept_while_result, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `OBGQ_ASSERT_NOW(a_div_count_range, i_clk, i_rst_n, r_state == S_DIV,
        r_cnt < (obgq_pkg::DIV_CW)'(obgq_pkg::DIV_STEPS))
    `OBGQ_ASSERT_NOW(a_default_when_not_found, i_clk, i_rst_n, o_out_valid && !o_found,
        o_ground_height == 32'(obgq_pkg::NO_GROUND))
    `OBGQ_ASSERT_NEXT(a_walk_in_range, i_clk, i_rst_n, r_state == S_ADDR && r_idx != r_n,
        r_idx <= r_n)
endmodule

FILE: dv/tb.sv
// Testbench for oriented_box_ground_query_top: box writes and ground queries.
// Depends on obgq_pkg and the RTL; a built-in predictor checks every result.
module tb;
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_cmd;
    logic [5:0]         i_box_index;
    logic signed [31:0] i_center_x;
    logic signed [31:0] i_center_y;
    logic [30:0]        i_half_width;
    logic signed [17:0] i_cosine;
    logic signed [17:0] i_sine;
    logic signed [31:0] i_query_x;
    logic signed [31:0] i_feet_height;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_ground_height;
    logic               o_found;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [6:0]         i_cfg_data;

    oriented_box_ground_query_top DUT (.*);

    // box table shadow, only ever read for written slots
    logic signed [31:0] sh_cx [obgq_pkg::MAX_BOXES];
    logic signed [31:0] sh_cy [obgq_pkg::MAX_BOXES];
    logic        [30:0] sh_hw [obgq_pkg::MAX_BOXES];
    logic signed [17:0] sh_cos[obgq_pkg::MAX_BOXES];
    logic signed [17:0] sh_sin[obgq_pkg::MAX_BOXES];
    logic        [6:0]  sh_count;

    typedef struct packed {
        logic signed [31:0] height;
        logic               found;
    } t_ground;

    typedef struct {
        logic               cmd;
        logic [5:0]         idx;
        logic signed [31:0] cx, cy;
        logic [30:0]        hw;
        logic signed [17:0] c, s;
        logic signed [31:0] qx, feet;
        bit                 has_exp;   // hand-typed expectation present
        t_ground            exp;
    } t_box_item;

    t_ground ground_q[$];
    int      mismatches;
    int      sender_idle, receiver_idle;  // percent
    bit      hold_rx;
    int      n_written;                   // not assigned or read anywhere in the bench

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #40000000;
        $display("*** FAILED ***");
        $finish;
    end

    // floor divide by 2^16 on 64-bit signed: arithmetic shift
    function automatic longint fl16(input longint v);
        fl16 = v >>> 16;
    endfunction

    function automatic t_ground predict_ground(input logic signed [31:0] qx,
                                               input logic signed [31:0] feet);
        longint  limit, best, dx, hw, c, s, num, t, g;
        int      n;
        t_ground r;
        limit = longint'(feet) - obgq_pkg::FEET_SLACK;
        best  = obgq_pkg::NO_GROUND;
        r.found = 1'b0;
        n = (sh_count > obgq_pkg::MAX_BOXES) ? obgq_pkg::MAX_BOXES : sh_count;
        for (int i = 0; i < n; i++) begin
            dx = longint'(qx) - longint'(sh_cx[i]);
            hw = longint'({1'b0, sh_hw[i]});
            c  = sh_cos[i];
            s  = sh_sin[i];
            if (c == 0 && s == 0) begin
                if (dx < -hw || dx > hw) continue;
                g = -(longint'(sh_cy[i]) + obgq_pkg::GROUND_OFFSET * 65536);
            end else begin
                if (c == 0) continue;   // vertical axis: skip, no divide
                num = dx + fl16(s * obgq_pkg::GROUND_OFFSET);
                t = (num * 65536) / c;  // SV truncates toward zero
                if (t < -hw || t > hw) continue;
                g = -(longint'(sh_cy[i]) + fl16(t * s) + c * obgq_pkg::GROUND_OFFSET);
            end
            if (g >= limit && g < best) begin
                best = g;
                r.found = 1'b1;
            end
        end
        if (best < -64'sd2147483648) best = -64'sd2147483648;
        r.height = best[31:0];
        return r;
    endfunction

    // sender side: one transfer, with random gaps before it
    task automatic send_item(input t_box_item it);
        while ($urandom_range(99) < sender_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= it.cmd;
        i_box_index   <= it.idx;
        i_center_x    <= it.cx;
        i_center_y    <= it.cy;
        i_half_width  <= it.hw;
        i_cosine      <= it.c;
        i_sine        <= it.s;
        i_query_x     <= it.qx;
        i_feet_height <= it.feet;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // transfer happened at this edge; update the shadow and predict
        if (it.cmd == obgq_pkg::CMD_WRITE) begin
            sh_cx[it.idx] = it.cx; sh_cy[it.idx] = it.cy; sh_hw[it.idx] = it.hw;
            sh_cos[it.idx] = it.c; sh_sin[it.idx] = it.s;
        end else begin
            t_ground p;
            p = predict_ground(it.qx, it.feet);
            if (it.has_exp && p !== it.exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row disagrees with predictor: %0d/%0b vs %0d/%0b",
                             it.exp.height, it.exp.found, p.height, p.found);
            end
            ground_q.push_back(p);
        end
    endtask

    task automatic write_count(input logic [6:0] v);
        i_in_valid <= 1'b0;
        wait (ground_q.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sh_count = v;
    endtask

    // receiver: random stalls, plus a long hold-off when hold_rx is set
    initial begin
        int hold;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_out_ready <= 1'b0;
                for (hold = 0; hold < 3000; hold++) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            i_out_ready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (ground_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d/%0b", o_ground_height, o_found);
            end else begin
                t_ground e;
                e = ground_q.pop_front();
                if (o_ground_height !== e.height || o_found !== e.found) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ground mismatch: exp %0d/%0b got %0d/%0b",
                                 e.height, e.found, o_ground_height, o_found);
                end
            end
        end
    end

    function automatic t_box_item mk_write(input int idx, input logic signed [31:0] cx,
            input logic signed [31:0] cy, input logic [30:0] hw,
            input logic signed [17:0] c, input logic signed [17:0] s);
        t_box_item it;
        it = '{default: '0};
        it.cmd = obgq_pkg::CMD_WRITE; it.idx = idx; it.cx = cx; it.cy = cy;
        it.hw = hw; it.c = c; it.s = s;
        it.qx = $urandom; it.feet = $urandom;   // ignored on writes
        return it;
    endfunction

    function automatic t_box_item mk_query(input logic signed [31:0] qx,
            input logic signed [31:0] feet, input bit he, input t_ground e);
        t_box_item it;
        it = '{default: '0};
        it.cmd = obgq_pkg::CMD_QUERY; it.qx = qx; it.feet = feet;
        it.idx = $urandom; it.cx = $urandom; it.cy = $urandom; it.hw = $urandom;
        it.c = $urandom; it.s = $urandom;
        it.has_exp = he; it.exp = e;
        return it;
    endfunction

    function automatic logic signed [17:0] rnd_trig();
        case ($urandom_range(5))
            0: rnd_trig = 18'sd65536;
            1: rnd_trig = -18'sd65536;
            2: rnd_trig = 18'sd0;
            default: rnd_trig = $signed(18'($urandom_range(131072))) - 18'sd65536;
        endcase
    endfunction

    function automatic t_box_item rnd_item(input int nslots);
        t_box_item it;
        logic signed [31:0] cx;
        if ($urandom_range(99) < 35) begin
            cx = $urandom_range(1) ? $urandom : $signed($urandom_range(40 << 16)) - (20 << 16);
            it = mk_write($urandom_range(nslots - 1), cx,
                          $signed($urandom_range(60 << 16)) - (40 << 16),
                          $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(8 << 16)),
                          rnd_trig(), rnd_trig());
        end else begin
            it = mk_query($urandom_range(3) == 0 ? $urandom
                              : $signed($urandom_range(40 << 16)) - (20 << 16),
                          $urandom_range(3) == 0 ? $urandom
                              : $signed($urandom_range(80 << 16)) - (40 << 16),
                          1'b0, '0);
        end
        return it;
    endfunction

    t_box_item directed[$];

    initial begin
        t_ground none, e;
        int nrand;
        mismatches = 0;
        hold_rx = 1'b0;
        sender_idle = 32; receiver_idle = 52;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0; i_cmd <= obgq_pkg::CMD_WRITE; i_box_index <= '0;
        i_center_x <= '0; i_center_y <= '0; i_half_width <= '0;
        i_cosine <= '0; i_sine <= '0; i_query_x <= '0; i_feet_height <= '0;
        i_cfg_valid <= 1'b0; i_cfg_data <= '0;
        sh_count = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        none.height = obgq_pkg::NO_GROUND; none.found = 1'b0;
        // after reset: zero boxes, nothing found
        directed.push_back(mk_query(32'sh7fffffff, 32'sh80000000, 1'b1, none));
        foreach (directed[i]) send_item(directed[i]);
        directed.delete();

        // directed table: fill all 64 slots so later counts stay in range
        for (int i = 0; i < obgq_pkg::MAX_BOXES; i++)
            send_item(mk_write(i, i << 18, -(20 << 16), 1 << 16, 0, 0));
        e.height = (20 << 16) - (9 << 16); e.found = 1'b1;
        directed.push_back(mk_write(0, 0, -(20 << 16), 31'h7fffffff, 0, 0));
        directed.push_back(mk_write(1, 32'sh80000000, 32'sh7fffffff, 0, 0, 0));
        directed.push_back(mk_write(2, 0, 0, 4 << 16, 18'sd65536, 18'sd0));
        directed.push_back(mk_write(3, 0, 0, 4 << 16, -18'sd65536, 18'sd0));
        directed.push_back(mk_write(4, 0, -(50 << 16), 31'h7fffffff, 18'sd0, 18'sd65536));
        directed.push_back(mk_write(5, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff,
                                    18'sd46341, -18'sd46341));
        directed.push_back(mk_write(6, 0, -(200 << 16), 8 << 16, 0, 0));
        foreach (directed[i]) send_item(directed[i]);
        directed.delete();
        write_count(7'd1);
        directed.push_back(mk_query(0, 0, 1'b1, e));
        directed.push_back(mk_query(0, (20 << 16), 1'b1, none)); // above feet slack
        foreach (directed[i]) send_item(directed[i]);
        directed.delete();
        write_count(7'd7);
        directed.push_back(mk_query(0, 32'sh80000000, 1'b0, '0));
        directed.push_back(mk_query(32'sh80000000, 32'sh80000000, 1'b0, '0));
        directed.push_back(mk_query(32'sh7fffffff, 32'sh80000000, 1'b0, '0));
        directed.push_back(mk_query(2 << 16, 0, 1'b0, '0));
        directed.push_back(mk_query(-(3 << 16), -(30 << 16), 1'b0, '0));
        foreach (directed[i]) send_item(directed[i]);
        directed.delete();
        write_count(7'd127);                   // beyond table: 64 searched
        send_item(mk_query(0, 32'sh80000000, 1'b0, '0));
        write_count(7'd0);
        send_item(mk_query(5, 5, 1'b1, none));

        // random phases, each with a new box count
        nrand = 0;
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin sender_idle = 52; receiver_idle = 32; end
            if (ph == 2) begin sender_idle = 0;  receiver_idle = 0;  end
            write_count(ph == 0 ? 7'd64 : 7'($urandom_range(1, 12)));
            for (int k = 0; k < 70; k++) begin
                if (ph == 2 && k == 5) hold_rx = 1'b1;
                send_item(rnd_item(obgq_pkg::MAX_BOXES));
                nrand++;
            end
        end

        // drain
        i_in_valid <= 1'b0;
        fork
            wait (ground_q.size() == 0);
        join
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && ground_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/obgq_pkg.sv
rtl/obgq_ram.sv
rtl/oriented_box_ground_query_top.sv
dv/tb.sv
